### src/swts_pkg.sv
package swts_pkg;

    // Width of every byte count, sum and frame stamp.
    localparam int unsigned BW = 32;

    // One stored grant of a connection window.
    typedef struct packed {
        logic [BW-1:0] gmin;
        logic [BW-1:0] gmax;
        logic [BW-1:0] stamp;
    } entry_t;

    // Smaller of two unsigned byte counts.
    function automatic logic [BW-1:0] umin(input logic [BW-1:0] a, input logic [BW-1:0] b);
        umin = (a < b) ? a : b;
    endfunction

endpackage

### src/sliding_window_traffic_shaper.sv
// Sliding-window traffic shaper. Each connection slot keeps a ring of past
// grants and the running sums of its minimum and maximum bytes. A query word
// (action 0) returns the wanted minimum and maximum bytes; an update word
// (action 1) records a grant and returns the new window sums. The per-slot
// record and the grant ring live in two single-port-read memories with
// registered reads, and one word is processed at a time. A query passes
// through S_META and S_DONE before its result is loaded into the output
// register. An update of a known slot appends the grant (a full ring first
// reads and drops its oldest entry), then reads and compares each oldest
// entry, dropping it while it is expired; the first update of a slot writes
// expire_age - 1 pre-filled default entries and then the grant. While the
// previous result still waits in the output register the finished word is
// held back. After its result is loaded the block returns to idle before it
// takes the next word. After reset the slot memory is cleared one slot at a
// time, during which no word is accepted.
module sliding_window_traffic_shaper #(
    parameter int CONNECTIONS  = 64,
    parameter int WINDOW_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [5:0]  s_conn_index,
    input  logic [31:0] s_now_frame,
    input  logic [31:0] s_min_frame_bytes,
    input  logic [31:0] s_max_frame_bytes,
    input  logic [31:0] s_min_window_bytes,
    input  logic [31:0] s_max_window_bytes,
    input  logic [6:0]  s_expire_age,
    input  logic [31:0] s_burst_limit,
    input  logic [31:0] s_payload_bytes,
    input  logic [31:0] s_granted_min,
    input  logic [31:0] s_granted_max,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_min_bytes,
    output logic [31:0] m_max_bytes,
    output logic        m_had_history
);

    localparam int BW = swts_pkg::BW;
    localparam int CW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int DW = $clog2(WINDOW_DEPTH);
    localparam int AW = $clog2(CONNECTIONS * WINDOW_DEPTH);
    localparam int MW = 1 + 2 * BW + DW + DW + 1;
    localparam int ENTRIES = CONNECTIONS * WINDOW_DEPTH;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_META   = 4'd2;
    localparam logic [3:0] S_FILL   = 4'd3;
    localparam logic [3:0] S_APPEND = 4'd4;
    localparam logic [3:0] S_ADROP  = 4'd5;
    localparam logic [3:0] S_EXPRD  = 4'd6;
    localparam logic [3:0] S_EXPCHK = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // Memories: per-slot record and grant ring.
    logic [MW-1:0]          meta_mem [CONNECTIONS];
    swts_pkg::entry_t       ent_mem  [ENTRIES];
    logic [MW-1:0]          meta_q;
    swts_pkg::entry_t       ent_q;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;

    // Latched input word.
    logic          act_reg, inr_reg, upd_reg, upd_next;
    logic [CW-1:0] cidx_reg;
    logic [BW-1:0] now_reg, fmin_reg, fmax_reg, wmin_reg, wmax_reg;
    logic [BW-1:0] burst_reg, pay_reg, gmin_reg, gmax_reg;
    logic [DW:0]   age_reg;

    // Working copy of the slot record.
    logic [BW-1:0] smin_reg, smin_next, smax_reg, smax_next;
    logic [DW-1:0] head_reg, head_next;
    logic [DW:0]   cnt_reg, cnt_next, k_reg, k_next;

    logic [BW-1:0] rmin_reg, rmin_next, rmax_reg, rmax_next;
    logic          rhist_reg, rhist_next;

    logic          m_valid_reg, m_valid_next;
    logic [BW-1:0] m_min_reg, m_min_next, m_max_reg, m_max_next;
    logic          m_hist_reg, m_hist_next;

    logic             meta_we;
    logic [CW-1:0]    meta_waddr;
    logic [MW-1:0]    meta_wdata;
    logic [CW-1:0]    meta_raddr;
    logic             ent_we, ent_re;
    logic [AW-1:0]    ent_waddr, ent_raddr;
    swts_pkg::entry_t ent_wdata;

    logic          accept;
    logic [15:0]   ci_ext;
    logic          s_inr;
    logic [10:0]   age_ext, age_cl;
    logic          known;
    logic [BW-1:0] q_smin, q_smax;
    logic [DW-1:0] q_head;
    logic [DW:0]   q_cnt;
    logic [DW+1:0] tail_sum;
    logic [DW-1:0] tail_pos, head_inc;
    logic [BW-1:0] qmin, qmax, age_now;
    logic          out_free;

    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_min_bytes   = m_min_reg;
    assign m_max_bytes   = m_max_reg;
    assign m_had_history = m_hist_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // Slot range check and expire age clamping of the incoming word.
    assign ci_ext     = 16'(s_conn_index);
    assign s_inr      = ci_ext < 16'(CONNECTIONS);
    assign meta_raddr = ci_ext[CW-1:0];
    assign age_ext    = 11'(s_expire_age);
    always_comb begin
        if (age_ext == 11'd0) begin
            age_cl = 11'd1;
        end else if (age_ext > 11'(WINDOW_DEPTH)) begin
            age_cl = 11'(WINDOW_DEPTH);
        end else begin
            age_cl = age_ext;
        end
    end

    // Fields of the slot record read back from memory.
    assign known  = inr_reg && meta_q[MW-1];
    assign q_smin = meta_q[MW-2 -: BW];
    assign q_smax = meta_q[MW-2-BW -: BW];
    assign q_head = meta_q[DW+DW : DW+1];
    assign q_cnt  = meta_q[DW:0];

    // Ring positions of the working record.
    assign tail_sum = (DW+2)'(head_reg) + (DW+2)'(cnt_reg);
    assign tail_pos = (tail_sum >= (DW+2)'(WINDOW_DEPTH)) ?
                      DW'(tail_sum - (DW+2)'(WINDOW_DEPTH)) : DW'(tail_sum);
    assign head_inc = (head_reg == DW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + DW'(1);
    assign age_now  = now_reg - ent_q.stamp;

    // Wanted sizes of a query.
    always_comb begin
        if (known) begin
            qmin = (wmin_reg > q_smin) ? wmin_reg - q_smin : '0;
            qmax = (wmax_reg > q_smax) ? wmax_reg - q_smax : '0;
        end else begin
            qmin = fmin_reg;
            qmax = fmax_reg;
        end
    end

    function automatic logic [AW-1:0] ent_addr(input logic [CW-1:0] c, input logic [DW-1:0] p);
        ent_addr = AW'(int'(c) * WINDOW_DEPTH + int'(p));
    endfunction

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        upd_next     = upd_reg;
        smin_next    = smin_reg;
        smax_next    = smax_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        rmin_next    = rmin_reg;
        rmax_next    = rmax_reg;
        rhist_next   = rhist_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_min_next   = m_min_reg;
        m_max_next   = m_max_reg;
        m_hist_next  = m_hist_reg;
        meta_we      = 1'b0;
        meta_waddr   = cidx_reg;
        meta_wdata   = {1'b1, smin_reg, smax_reg, head_reg, cnt_reg};
        ent_we       = 1'b0;
        ent_waddr    = ent_addr(cidx_reg, tail_pos);
        ent_wdata    = '{gmin: gmin_reg, gmax: gmax_reg, stamp: now_reg};
        ent_re       = 1'b0;
        ent_raddr    = ent_addr(cidx_reg, head_reg);
        unique case (state_reg)
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '0;
                clr_next   = clr_reg + CW'(1);
                if (clr_reg == CW'(CONNECTIONS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_META;
                end
            end
            S_META: begin
                rhist_next = known;
                upd_next   = 1'b0;
                if (!act_reg) begin
                    rmin_next  = swts_pkg::umin(swts_pkg::umin(qmin, burst_reg), pay_reg);
                    rmax_next  = swts_pkg::umin(swts_pkg::umin(qmax, burst_reg), pay_reg);
                    state_next = S_DONE;
                end else if (!inr_reg) begin
                    rmin_next  = '0;
                    rmax_next  = '0;
                    state_next = S_DONE;
                end else if (!known) begin
                    upd_next   = 1'b1;
                    smin_next  = '0;
                    smax_next  = '0;
                    head_next  = '0;
                    cnt_next   = '0;
                    k_next     = age_reg - (DW+1)'(1);
                    state_next = S_FILL;
                end else begin
                    upd_next   = 1'b1;
                    smin_next  = q_smin;
                    smax_next  = q_smax;
                    head_next  = q_head;
                    cnt_next   = q_cnt;
                    state_next = S_APPEND;
                end
            end
            // First update: default entries oldest first, then the grant.
            S_FILL: begin
                ent_we   = 1'b1;
                cnt_next = cnt_reg + (DW+1)'(1);
                if (k_reg != '0) begin
                    ent_wdata = '{gmin: fmin_reg, gmax: fmax_reg,
                                  stamp: now_reg - BW'(k_reg)};
                    smin_next = smin_reg + fmin_reg;
                    smax_next = smax_reg + fmax_reg;
                    k_next    = k_reg - (DW+1)'(1);
                end else begin
                    smin_next  = smin_reg + gmin_reg;
                    smax_next  = smax_reg + gmax_reg;
                    rmin_next  = smin_reg + gmin_reg;
                    rmax_next  = smax_reg + gmax_reg;
                    state_next = S_DONE;
                end
            end
            // Append to a known window; a full ring first reads its oldest entry.
            S_APPEND: begin
                if (cnt_reg == (DW+1)'(WINDOW_DEPTH)) begin
                    ent_re     = 1'b1;
                    state_next = S_ADROP;
                end else begin
                    ent_we     = 1'b1;
                    cnt_next   = cnt_reg + (DW+1)'(1);
                    smin_next  = smin_reg + gmin_reg;
                    smax_next  = smax_reg + gmax_reg;
                    state_next = S_EXPRD;
                end
            end
            S_ADROP: begin
                ent_we     = 1'b1;
                ent_waddr  = ent_addr(cidx_reg, head_reg);
                smin_next  = smin_reg - ent_q.gmin + gmin_reg;
                smax_next  = smax_reg - ent_q.gmax + gmax_reg;
                head_next  = head_inc;
                state_next = S_EXPRD;
            end
            // Expiry loop: read the oldest entry, then drop it if too old.
            S_EXPRD: begin
                if (cnt_reg == '0) begin
                    rmin_next  = smin_reg;
                    rmax_next  = smax_reg;
                    state_next = S_DONE;
                end else begin
                    ent_re     = 1'b1;
                    state_next = S_EXPCHK;
                end
            end
            S_EXPCHK: begin
                if (age_now >= BW'(age_reg)) begin
                    smin_next  = smin_reg - ent_q.gmin;
                    smax_next  = smax_reg - ent_q.gmax;
                    head_next  = head_inc;
                    cnt_next   = cnt_reg - (DW+1)'(1);
                    state_next = S_EXPRD;
                end else begin
                    rmin_next  = smin_reg;
                    rmax_next  = smax_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_min_next   = rmin_reg;
                    m_max_next   = rmax_reg;
                    m_hist_next  = rhist_reg;
                    meta_we      = upd_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Input word capture.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg   <= s_action;
            inr_reg   <= s_inr;
            cidx_reg  <= meta_raddr;
            now_reg   <= s_now_frame;
            fmin_reg  <= s_min_frame_bytes;
            fmax_reg  <= (s_max_frame_bytes < s_min_frame_bytes) ?
                         s_min_frame_bytes : s_max_frame_bytes;
            wmin_reg  <= s_min_window_bytes;
            wmax_reg  <= s_max_window_bytes;
            age_reg   <= (DW+1)'(age_cl);
            burst_reg <= s_burst_limit;
            pay_reg   <= s_payload_bytes;
            gmin_reg  <= s_granted_min;
            gmax_reg  <= s_granted_max;
        end
    end

    // Working and result registers.
    always_ff @(posedge aclk) begin
        upd_reg    <= upd_next;
        smin_reg   <= smin_next;
        smax_reg   <= smax_next;
        head_reg   <= head_next;
        k_reg      <= k_next;
        rmin_reg   <= rmin_next;
        rmax_reg   <= rmax_next;
        rhist_reg  <= rhist_next;
        m_min_reg  <= m_min_next;
        m_max_reg  <= m_max_next;
        m_hist_reg <= m_hist_next;
    end

    // Slot record memory.
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (accept) begin
            meta_q <= meta_mem[meta_raddr];
        end
    end

    // Grant ring memory.
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            ent_q <= ent_mem[ent_raddr];
        end
    end

    // The ring never holds more entries than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (DW+1)'(WINDOW_DEPTH))
        else $error("ring count above depth");

    // A result is only loaded while the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=> (m_min_bytes == $past(m_min_bytes)))
        else $error("pending result overwritten");

    // The expiry check only runs on a ring that holds entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXPCHK) |-> (cnt_reg != '0))
        else $error("expiry check on empty ring");

    // No word is taken during the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready && !m_valid)
        else $error("activity during clearing pass");

endmodule
